### rtl/lss_pkg.sv
// Package: types, codes and constants shared by the LIFO stack with search.
package lss_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WORD_W    = 32;
  localparam int POS_W     = 7;
  localparam int OP_W      = 3;
  localparam int ST_W      = 2;

  localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
  localparam logic [OP_W-1:0] OP_POP     = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK    = 3'd2;
  localparam logic [OP_W-1:0] OP_DISPLAY = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [WORD_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]          status;
    logic signed [WORD_W-1:0] word;
    logic [POS_W-1:0]         position;
    logic                     last;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_TOP,
    S_SCAN,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    SRC_PUSH,
    SRC_RD,
    SRC_PEND,
    SRC_STATUS
  } src_t;

  // controller -> datapath
  typedef struct packed {
    logic            load;
    logic            rd_en;
    logic            p_inc;
    logic            wr_en;
    logic            cnt_inc;
    logic            cnt_dec;
    logic            pend_set;
    logic            pend_clr;
    logic            emit;
    src_t            src;
    logic [ST_W-1:0] status;
    logic            last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            empty;
    logic            scan_last;
    logic            match;
    logic            pend_valid;
    logic            out_free;
  } sts_t;

endpackage

### rtl/lss_dp.sv
// Datapath: stack memory, count, scan pointer, pending match and result register.
module lss_dp import lss_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  cmd_t cmd,
  output sts_t sts,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data;
  logic [WORD_W-1:0] key;
  logic [WORD_W-1:0] pend_word;
  logic [CW-1:0]     pend_pos;
  logic              pend_valid;
  logic [OP_W-1:0]   op;
  logic [CW-1:0]     count;
  logic [CW-1:0]     p;
  logic [CW-1:0]     rd_pos;
  logic [CW-1:0]     rd_diff;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;

  assign rd_pos  = cmd.p_inc ? p + CW'(1) : p;
  assign rd_diff = count - rd_pos;
  assign rd_addr = rd_diff[AW-1:0];
  assign wr_addr = count[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= key;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= req.op;
      key <= req.value;
    end
    if (cmd.pend_set) begin
      pend_word <= rd_data;
      pend_pos  <= p;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      p          <= CW'(1);
      pend_valid <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        count <= count + CW'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CW'(1);
      end
      if (cmd.load) begin
        p <= CW'(1);
      end else if (cmd.p_inc) begin
        p <= p + CW'(1);
      end
      if (cmd.pend_set) begin
        pend_valid <= 1'b1;
      end else if (cmd.pend_clr) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp.last <= cmd.last;
      case (cmd.src)
        SRC_PUSH: begin
          rsp.status   <= ST_OK;
          rsp.word     <= key;
          rsp.position <= POS_W'(1);
        end
        SRC_RD: begin
          rsp.status   <= ST_OK;
          rsp.word     <= rd_data;
          rsp.position <= POS_W'(p);
        end
        SRC_PEND: begin
          rsp.status   <= ST_OK;
          rsp.word     <= pend_word;
          rsp.position <= POS_W'(pend_pos);
        end
        default: begin
          rsp.status   <= cmd.status;
          rsp.word     <= '0;
          rsp.position <= '0;
        end
      endcase
    end
  end

  always_comb begin
    sts.op         = op;
    sts.full       = (count == CW'(DEPTH));
    sts.empty      = (count == '0);
    sts.scan_last  = (p == count);
    sts.match      = (rd_data == key);
    sts.pend_valid = pend_valid;
    sts.out_free   = !rsp_valid || rsp_ready;
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("stack count above depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |-> !cmd.emit)
    else $error("result emitted over a stalled item");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> (count < CW'(DEPTH)) && cmd.cnt_inc)
    else $error("push write while full");

  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_dec |=> count == $past(count) - CW'(1))
    else $error("pop did not shrink the stack");
`endif

endmodule

### rtl/lss_ctrl.sv
// Controller: state machine that sequences push, pop, peek, display and search.
module lss_ctrl import lss_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    cmd.src    = SRC_STATUS;
    cmd.status = ST_OK;
    cmd.last   = 1'b1;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.op) inside
          OP_PUSH: begin
            if (sts.out_free) begin
              cmd.emit = 1'b1;
              if (sts.full) begin
                cmd.status = ST_FULL;
              end else begin
                cmd.src     = SRC_PUSH;
                cmd.wr_en   = 1'b1;
                cmd.cnt_inc = 1'b1;
              end
              state_next = S_IDLE;
            end
          end
          OP_POP, OP_PEEK, OP_DISPLAY, OP_SEARCH: begin
            if (sts.empty) begin
              if (sts.out_free) begin
                cmd.emit   = 1'b1;
                cmd.status = ST_EMPTY;
                state_next = S_IDLE;
              end
            end else begin
              cmd.rd_en    = 1'b1;
              cmd.pend_clr = 1'b1;
              state_next   = (sts.op == OP_POP || sts.op == OP_PEEK) ? S_TOP : S_SCAN;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_TOP: begin
        if (sts.out_free) begin
          cmd.emit    = 1'b1;
          cmd.src     = SRC_RD;
          cmd.cnt_dec = (sts.op == OP_POP);
          state_next  = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts.op == OP_DISPLAY) begin
          if (sts.out_free) begin
            cmd.emit = 1'b1;
            cmd.src  = SRC_RD;
            cmd.last = sts.scan_last;
            if (sts.scan_last) begin
              state_next = S_IDLE;
            end else begin
              cmd.p_inc = 1'b1;
              cmd.rd_en = 1'b1;
            end
          end
        end else if (!(sts.match && sts.pend_valid && !sts.out_free)) begin
          if (sts.match) begin
            cmd.pend_set = 1'b1;
            if (sts.pend_valid) begin
              cmd.emit = 1'b1;
              cmd.src  = SRC_PEND;
              cmd.last = 1'b0;
            end
          end
          if (sts.scan_last) begin
            state_next = S_FIN;
          end else begin
            cmd.p_inc = 1'b1;
            cmd.rd_en = 1'b1;
          end
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.pend_valid) begin
            cmd.src = SRC_PEND;
          end else begin
            cmd.status = ST_NOTFOUND;
          end
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> state == S_DISPATCH)
    else $error("accepted item not dispatched");

  a_pend_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.src == SRC_PEND && state == S_SCAN) |-> !cmd.last)
    else $error("earlier match marked last");

  a_fin_search: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN |-> sts.op == OP_SEARCH)
    else $error("final search step outside a search");
`endif

endmodule

### rtl/lifo_stack_with_search_core.sv
// Top level: LIFO stack of signed words with pop, peek, listing and key search.
//
// Request channel (req_valid/req_ready, req): op and value. Response channel
// (rsp_valid/rsp_ready, rsp): status, word, 1-based position from the top and
// a last flag on the final response of each item.
// One item is handled at a time; req_ready is high while the controller idles.
// Pop and peek: S_DISPATCH reads the top word, then S_TOP registers the
// response once the output register is free. Push and any item on an empty
// stack: S_DISPATCH registers the response once the output register is free.
// Display: S_DISPATCH reads the top word, then S_SCAN emits one response per
// cycle while rsp_ready does not stall it, through the single registered read
// port of the stack memory. Search ends in S_FIN, which releases its final match
// or the not-found response. Unused op codes are accepted and dropped, unanswered.
// Responses leave from an output register; while rsp_ready is low the scan
// halts at the next response to emit and resumes when it is taken.
// Reset empties the stack (count to zero); memory contents are not cleared.
module lifo_stack_with_search_core import lss_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  cmd_t cmd;
  sts_t sts;

  lss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lss_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

### tb/lifo_stack_with_search_core_tb.sv
// Testbench for the LIFO stack with search: directed and random items checked by a stack predictor.
`timescale 1ns / 1ps

module lifo_stack_with_search_core_tb import lss_pkg::*;;

  localparam int N_ITEMS      = 80;
  localparam int HOLD_CYCLES  = 90;
  localparam int HOLD_AFTER   = 40;
  localparam int DRAIN_CYCLES = 24;
  localparam int TIMEOUT_NS   = 5_000_000;
  localparam int MAX_PRINTS   = 50;

  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
  localparam logic [OP_W-1:0] OP_UNUSED_LO = OP_SEARCH + 3'd1;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = '1;

  class lifo_scoreboard;
    logic signed [WORD_W-1:0] stack_words [DEPTH_DEF];
    int   stack_used = 0;
    rsp_t want_q[$];
    int   mismatches = 0;
    int   checked = 0;
    int   n_full = 0;
    int   n_empty = 0;
    int   n_miss = 0;
    int   n_multi = 0;
    int   n_lists = 0;

    function void add_want(logic [ST_W-1:0] status, logic signed [WORD_W-1:0] word,
                           int pos, bit last);
      rsp_t w;
      w.status   = status;
      w.word     = word;
      w.position = POS_W'(pos);
      w.last     = last;
      want_q.push_back(w);
    endfunction

    // Apply one accepted item to the stack copy and queue the results it causes.
    function void note_item(req_t r);
      int hits;
      int k;
      if (r.op > OP_SEARCH) return;
      if (r.op == OP_PUSH) begin
        if (stack_used >= DEPTH_DEF) begin
          add_want(ST_FULL, '0, 0, 1'b1);
          n_full++;
        end else begin
          stack_words[stack_used] = r.value;
          stack_used++;
          add_want(ST_OK, r.value, 1, 1'b1);
        end
        return;
      end
      if (stack_used == 0) begin
        add_want(ST_EMPTY, '0, 0, 1'b1);
        n_empty++;
        return;
      end
      case (r.op)
        OP_POP: begin
          stack_used--;
          add_want(ST_OK, stack_words[stack_used], 1, 1'b1);
        end
        OP_PEEK: begin
          add_want(ST_OK, stack_words[stack_used-1], 1, 1'b1);
        end
        OP_DISPLAY: begin
          n_lists++;
          for (int p = 1; p <= stack_used; p++)
            add_want(ST_OK, stack_words[stack_used-p], p, p == stack_used);
        end
        default: begin
          hits = 0;
          for (int p = 1; p <= stack_used; p++)
            if (stack_words[stack_used-p] == r.value) hits++;
          if (hits == 0) begin
            add_want(ST_NOTFOUND, '0, 0, 1'b1);
            n_miss++;
          end else begin
            if (hits > 1) n_multi++;
            k = 0;
            for (int p = 1; p <= stack_used; p++) begin
              if (stack_words[stack_used-p] == r.value) begin
                k++;
                add_want(ST_OK, stack_words[stack_used-p], p, k == hits);
              end
            end
          end
        end
      endcase
    endfunction

    task flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(rsp_t got);
      rsp_t want;
      checked++;
      if (want_q.size() == 0) begin
        flag_mismatch($sformatf("result with none pending: status %0d word %0d pos %0d last %0d",
                                got.status, got.word, got.position, got.last));
        return;
      end
      want = want_q.pop_front();
      if (got.status !== want.status)
        flag_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.word !== want.word)
        flag_mismatch($sformatf("word got %0d want %0d", got.word, want.word));
      if (got.position !== want.position)
        flag_mismatch($sformatf("position got %0d want %0d", got.position, want.position));
      if (got.last !== want.last)
        flag_mismatch($sformatf("last got %0d want %0d", got.last, want.last));
    endtask
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  lifo_scoreboard sb;
  int items_sent;
  bit tx_calm;

  lifo_stack_with_search_core u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9)) inside
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return -1;
      3: return 0;
      4, 5: return $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  // Search keys mostly hit a stored word so matches and multi-matches show up.
  function automatic logic signed [WORD_W-1:0] pick_key();
    if (sb.stack_used > 0 && $urandom_range(0, 2) != 0)
      return sb.stack_words[$urandom_range(0, sb.stack_used - 1)];
    return pick_word();
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return OP_PUSH;
    if (r < 55) return OP_POP;
    if (r < 65) return OP_PEEK;
    if (r < 75) return OP_DISPLAY;
    if (r < 95) return OP_SEARCH;
    return OP_UNUSED_LO + OP_W'($urandom_range(0, 2));
  endfunction

  task automatic issue(input logic [OP_W-1:0] op, input logic signed [WORD_W-1:0] value);
    req_t r;
    int gap;
    r.op    = op;
    r.value = value;
    gap     = pick_gap(tx_calm);
    @(negedge clk);
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid = 1'b1;
    req       = r;
    do @(posedge clk); while (!req_ready);
    sb.note_item(r);
    if (op <= OP_SEARCH) items_sent++;
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_result(rsp);
  end

  // Output side: random stalls, calm stretches, and one long hold-off that backs up the input.
  initial begin
    int stall;
    int tick;
    bit calm;
    bit held;
    stall     = 0;
    tick      = 0;
    calm      = 1'b0;
    held      = 1'b0;
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (tick % 64 == 0) calm = ($urandom_range(0, 2) == 0);
      if (!held && sb.checked >= HOLD_AFTER) begin
        held      = 1'b1;
        rsp_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (stall > 0) begin
        stall--;
        rsp_ready = 1'b0;
      end else begin
        rsp_ready = 1'b1;
        stall     = pick_gap(calm);
      end
    end
  end

  initial begin
    int phase;
    int sel;
    int rand_start;
    logic [OP_W-1:0] op;
    sb         = new;
    rst        = 1'b1;
    req_valid  = 1'b0;
    req        = '0;
    items_sent = 0;
    tx_calm    = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty stack, unused codes, extremes, duplicates
    issue(OP_POP, 0);
    issue(OP_PEEK, 0);
    issue(OP_DISPLAY, 0);
    issue(OP_SEARCH, WORD_MIN);
    issue(OP_UNUSED_LO, WORD_MAX);
    issue(OP_UNUSED_LO + 3'd1, -1);
    issue(OP_UNUSED_HI, WORD_MIN);
    issue(OP_PUSH, WORD_MIN);
    issue(OP_PUSH, WORD_MAX);
    issue(OP_PUSH, 0);
    issue(OP_PUSH, -1);
    issue(OP_PUSH, WORD_MAX);
    issue(OP_PEEK, 0);
    issue(OP_DISPLAY, 0);
    issue(OP_SEARCH, WORD_MAX);
    issue(OP_SEARCH, WORD_MIN);
    issue(OP_SEARCH, 12345);
    issue(OP_POP, 0);
    issue(OP_POP, 0);
    issue(OP_PEEK, 0);

    rand_start = items_sent;
    phase      = 0;
    while (items_sent - rand_start < N_ITEMS) begin
      sel     = (phase == 0) ? 0 : (phase == 1) ? 3 : $urandom_range(0, 9);
      tx_calm = ($urandom_range(0, 3) == 0);
      if (sel < 2) begin
        while (sb.stack_used < DEPTH_DEF) issue(OP_PUSH, pick_word());
        repeat ($urandom_range(1, 2)) issue(OP_PUSH, pick_word());
        issue(OP_DISPLAY, 0);
        issue(OP_SEARCH, pick_key());
      end else if (sel < 4) begin
        while (sb.stack_used > 0)
          issue(($urandom_range(0, 3) == 0) ? OP_PEEK : OP_POP, pick_word());
        issue(OP_POP, pick_word());
        issue(OP_SEARCH, pick_word());
      end else begin
        repeat (8) begin
          op = pick_op();
          issue(op, (op == OP_SEARCH) ? pick_key() : pick_word());
        end
      end
      phase++;
    end
    @(negedge clk);
    req_valid = 1'b0;

    while (sb.want_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d items, %0d results compared, %0d listings, %0d multi-match searches.",
             items_sent, sb.checked, sb.n_lists, sb.n_multi);
    $display("Refusals seen: %0d pushes on a full stack, %0d ops on an empty one, %0d misses.",
             sb.n_full, sb.n_empty, sb.n_miss);
    if (sb.mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #TIMEOUT_NS;
    $display("FAIL");
    $finish;
  end

endmodule
